// ===== rtl/mke_pkg.sv =====
// Shared types, constants and the character decode function for the masked k-mer encoder.
`default_nettype none

package mke_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KMER_LENGTH      = 2'd0,
    REG_WINDOW_STRIDE    = 2'd1,
    REG_SEGMENT_LENGTH   = 2'd2,
    REG_SCALE_RECIPROCAL = 2'd3
  } cfg_reg_t;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned EncW   = 32;
  localparam int unsigned IndexW = 16;

  localparam logic [3:0]  KmerLengthRst      = 4'd3;
  localparam logic [4:0]  WindowStrideRst    = 5'd3;
  localparam logic [15:0] SegmentLengthRst   = 16'd28500;
  localparam logic [31:0] ScaleReciprocalRst = 32'd1048832;

  // Q1.30 plus one and the offset that maps zero to minus one.
  localparam logic [EncW-1:0] EncOne = 32'h4000_0000;

  // One decoded character.
  typedef struct packed {
    logic       bad;
    logic [3:0] sym;
  } sym_t;

  // Position of a character in the 16-letter alphabet AMVHCRSNWUYBGKDT.
  // Characters outside it decode to symbol zero with the bad flag set.
  function automatic sym_t mke_decode(input logic [7:0] ch);
    sym_t res;
    res.bad = 1'b0;
    case (ch)
      "A":     res.sym = 4'd0;
      "M":     res.sym = 4'd1;
      "V":     res.sym = 4'd2;
      "H":     res.sym = 4'd3;
      "C":     res.sym = 4'd4;
      "R":     res.sym = 4'd5;
      "S":     res.sym = 4'd6;
      "N":     res.sym = 4'd7;
      "W":     res.sym = 4'd8;
      "U":     res.sym = 4'd9;
      "Y":     res.sym = 4'd10;
      "B":     res.sym = 4'd11;
      "G":     res.sym = 4'd12;
      "K":     res.sym = 4'd13;
      "D":     res.sym = 4'd14;
      "T":     res.sym = 4'd15;
      default: begin
        res.sym = 4'd0;
        res.bad = 1'b1;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mke_scaler.sv =====
// Linear Q1.30 scaling of a k-mer code by the programmed reciprocal, with saturation.
`default_nettype none

module mke_scaler
  import mke_pkg::*;
(
  input  wire logic [CodeW-1:0] code,
  input  wire logic [31:0]      recip,
  output logic      [EncW-1:0]  encoded
);

  logic [63:0] prod;

  assign prod = 64'(code) * 64'(recip);

  // Half the product is at most 2^31 - 1 when the upper word is zero, so the
  // only overflow is a half product that reaches 2^31; it pins at plus one.
  always_comb begin
    if (prod[63:32] != 32'd0) begin
      encoded = EncOne;
    end else begin
      encoded = {1'b0, prod[31:1]} - EncOne;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/masked_kmer_encoder_core.sv =====
// Top level of the masked k-mer encoder: sequence state, window build and output pipeline.
//
// The input channel carries one ASCII character per request in in_tdata, its keep
// bit in in_tuser and an end-of-sequence mark in in_tlast. A request with tlast
// high clears the window and all per-sequence counters; its character is ignored.
// Kept characters up to segment_length per sequence are decoded into 4-bit symbols
// and shifted into a base-16 window. Every window_stride-th complete window of
// kmer_length symbols produces one result request carrying the code, the signed
// Q1.30 linear encoding, the k-mer ordinal and a bad-character flag.
// An accepted input request passes through the middle register, which registers the
// candidate code as the window and counters update, and then the output register,
// which takes the result of the 32x32 multiply. Throughput is one input request
// per cycle while the receiver takes results.
// When the receiver stalls, the output register holds its result and the middle
// register still takes one more request, so in_tready drops only when both are
// full. A synchronous active-low reset restores the default register values,
// clears all sequence state and empties the pipeline. Configuration writes are
// always accepted and should only be issued while the pipeline is empty.
`default_nettype none

module masked_kmer_encoder_core
  import mke_pkg::*;
#(
  parameter int unsigned MAX_KMER   = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tuser,   // [0] keep
  input  wire logic        in_tlast,   // end_of_sequence
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [31:0] kmer_code, [63:32] encoded, [79:64] kmer_index
  output logic             out_tuser,  // [0] bad_symbol
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned WinW = 4 * MAX_KMER;
  // Width that holds both a count and a segment length for comparison.
  localparam int unsigned CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Configuration registers.
  logic [3:0]  kmer_len_r;
  logic [4:0]  stride_r;
  logic [15:0] seg_len_r;
  logic [31:0] recip_r;

  // Sequence state.
  logic [WinW-1:0]       win_r;
  logic [MAX_KMER-1:0]   badw_r;
  logic [COUNT_BITS-1:0] kept_r;
  logic [3:0]            phase_r;
  logic [COUNT_BITS-1:0] emitted_r;

  // Middle stage: candidate result awaiting the multiply.
  logic              p1_valid_r;
  logic [CodeW-1:0]  p1_code_r;
  logic [IndexW-1:0] p1_index_r;
  logic              p1_bad_r;

  // Output stage.
  logic              out_valid_r;
  logic [CodeW-1:0]  out_code_r;
  logic [EncW-1:0]   out_enc_r;
  logic [IndexW-1:0] out_index_r;
  logic              out_bad_r;

  logic                  in_acc;
  logic                  out_adv;
  logic                  p1_adv;
  sym_t                  dec;
  logic [WinW-1:0]       win_nxt;
  logic [MAX_KMER-1:0]   badw_nxt;
  logic [COUNT_BITS-1:0] kept_nxt;
  logic [3:0]            phase_nxt;
  logic [4:0]            phase_sum;
  logic [3:0]            k_eff;
  logic [4:0]            stride_eff;
  logic                  take;
  logic                  full;
  logic                  emit;
  logic [WinW-1:0]       wmask;
  logic [MAX_KMER-1:0]   kmask;
  logic [CmpW-1:0]       emitted_wide;
  logic [EncW-1:0]       enc;

  assign cfg_ready = 1'b1;

  // The output register advances when empty or taken; the middle register
  // advances when empty or when it can move into the output register.
  assign out_adv   = !out_valid_r || out_tready;
  assign p1_adv    = !p1_valid_r || out_adv;
  assign in_tready = p1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign dec = mke_decode(in_tdata);

  // Out-of-range lengths and strides are clamped into their legal ranges.
  always_comb begin
    if (kmer_len_r == 4'd0) begin
      k_eff = 4'd1;
    end else if (kmer_len_r > 4'(MAX_KMER)) begin
      k_eff = 4'(MAX_KMER);
    end else begin
      k_eff = kmer_len_r;
    end
    if (stride_r == 5'd0) begin
      stride_eff = 5'd1;
    end else if (stride_r > 5'd16) begin
      stride_eff = 5'd16;
    end else begin
      stride_eff = stride_r;
    end
  end

  assign take     = in_tuser && (CmpW'(kept_r) < CmpW'(seg_len_r));
  assign win_nxt  = WinW'({win_r, dec.sym});
  assign badw_nxt = MAX_KMER'({badw_r, dec.bad});
  assign kept_nxt = kept_r + 1'b1;
  assign full     = CmpW'(kept_nxt) >= CmpW'(k_eff);

  // A phase left above a newly lowered stride restarts at zero after this window.
  assign phase_sum = {1'b0, phase_r} + 5'd1;
  assign phase_nxt = (phase_sum >= stride_eff) ? 4'd0 : phase_sum[3:0];

  assign emit = take && full && (phase_r == 4'd0);

  always_comb begin
    for (int i = 0; i < MAX_KMER; i++) begin
      kmask[i]         = (i < int'(k_eff));
      wmask[4*i +: 4]  = {4{kmask[i]}};
    end
  end

  assign emitted_wide = CmpW'(emitted_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KmerLengthRst;
      stride_r   <= WindowStrideRst;
      seg_len_r  <= SegmentLengthRst;
      recip_r    <= ScaleReciprocalRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KMER_LENGTH:      kmer_len_r <= cfg_data[3:0];
        REG_WINDOW_STRIDE:    stride_r   <= cfg_data[4:0];
        REG_SEGMENT_LENGTH:   seg_len_r  <= cfg_data[15:0];
        REG_SCALE_RECIPROCAL: recip_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence state update on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      badw_r    <= '0;
      kept_r    <= '0;
      phase_r   <= '0;
      emitted_r <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        win_r     <= '0;
        badw_r    <= '0;
        kept_r    <= '0;
        phase_r   <= '0;
        emitted_r <= '0;
      end else if (take) begin
        win_r  <= win_nxt;
        badw_r <= badw_nxt;
        kept_r <= kept_nxt;
        if (full) begin
          phase_r <= phase_nxt;
        end
        if (emit) begin
          emitted_r <= emitted_r + 1'b1;
        end
      end
    end
  end

  // Middle register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_adv) begin
      p1_valid_r <= in_acc && !in_tlast && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      p1_code_r  <= CodeW'(win_nxt & wmask);
      p1_index_r <= emitted_wide[IndexW-1:0];
      p1_bad_r   <= (badw_nxt & kmask) != '0;
    end
  end

  mke_scaler u_scaler (
    .code    (p1_code_r),
    .recip   (recip_r),
    .encoded (enc)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p1_valid_r) begin
      out_code_r  <= p1_code_r;
      out_enc_r   <= enc;
      out_index_r <= p1_index_r;
      out_bad_r   <= p1_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_enc_r, out_code_r};
  assign out_tuser  = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/mke_checker.sv =====
// Port-level checker for the masked k-mer encoder, bound to the top level.
`default_nettype none

module mke_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // With the output register empty the pipeline must take a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // The encoding stays within minus one to plus one in Q1.30.
  a_enc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[63:32]) <= 32'sh4000_0000) &&
                   ($signed(out_tdata[63:32]) >= -32'sh4000_0000))
    else $error("encoding out of range");

  // A zero code encodes to exactly minus one.
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] == 32'd0) |-> out_tdata[63:32] == 32'hC000_0000)
    else $error("zero code not at minus one");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind masked_kmer_encoder_core mke_checker u_mke_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
